[rtl/jacd_pkg.sv]
// Shared types, widths and constants for the joystick axis calibration block.
package jacd_pkg;

  localparam int AXES      = 4;
  localparam int AXIS_W    = 2;
  localparam int SAMPLE_W  = 12;
  localparam int POS_W     = 8;
  localparam int MARGIN_W  = 6;
  localparam int QUO_W     = 7;
  localparam int NUM_W     = 19;
  localparam int DEN_W     = 12;
  localparam int CELLS     = QUO_W;
  localparam int SHIFT_W   = 3;
  localparam int SCALE_SH  = 7;
  localparam int PADDR_W   = 5;
  localparam int PDATA_W   = 32;
  localparam int REG_IDX_W = 3;

  localparam logic [POS_W-1:0] POS_ZERO   = 8'd0;
  localparam logic [POS_W-1:0] POS_LOW_TOP = 8'd127;
  localparam logic [POS_W-1:0] POS_MID    = 8'd128;
  localparam logic [POS_W-1:0] POS_HI_BASE = 8'd129;
  localparam logic [POS_W-1:0] POS_HI_TOP = 8'd254;
  localparam logic [POS_W-1:0] POS_MAX    = 8'd255;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_CAL_LOW,
    REG_CAL_HIGH,
    REG_CENTRE0,
    REG_CENTRE1,
    REG_CENTRE2,
    REG_CENTRE3,
    REG_DEAD_MARGIN
  } reg_idx_e;

  typedef struct packed {
    logic [SAMPLE_W-1:0]           cal_low;
    logic [SAMPLE_W-1:0]           cal_high;
    logic [AXES-1:0][SAMPLE_W-1:0] centre;
    logic [MARGIN_W-1:0]           margin;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    cal_low:  12'd10,
    cal_high: 12'd4080,
    centre:   {12'd1964, 12'd2142, 12'd1960, 12'd2103},
    margin:   6'd10
  };

  // One item in flight through a divider chain; the quotient of forced items is ignored.
  typedef struct packed {
    logic [AXIS_W-1:0] axis;
    logic              forced;
    logic [POS_W-1:0]  base;
    logic [NUM_W-1:0]  rem;
    logic [DEN_W-1:0]  den;
    logic [QUO_W-1:0]  quo;
  } div_item_t;

endpackage

[rtl/jacd_if.sv]
// Valid/ready stream interfaces for sample beats and position beats.
interface jacd_in_if import jacd_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [AXIS_W-1:0]   axis;
  logic [SAMPLE_W-1:0] raw_sample;

  modport source (output valid, output axis, output raw_sample, input ready);
  modport sink   (input valid, input axis, input raw_sample, output ready);
endinterface

interface jacd_out_if import jacd_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [AXIS_W-1:0] axis_tag;
  logic [POS_W-1:0]  position;

  modport source (output valid, output axis_tag, output position, input ready);
  modport sink   (input valid, input axis_tag, input position, output ready);
endinterface

[rtl/joystick_axis_calibrate_deadzone_core.sv]
// Top level of the joystick axis calibration and deadzone block.
//
// Usage: software programs cal_low, cal_high, the four axis centres and the
// deadzone margin over the APB-style port (register i at byte address 4*i)
// while no sample beats are in flight; pready is always high, reads return
// the stored values. Sample beats (axis, raw_sample) enter on in_i, position
// beats (axis_tag, position) leave on out_o in the same order, one per sample.
//
// Datapath: an entry stage clamps against the calibration points and sets up
// the segment division, a row of seven restoring divider cells produces one
// quotient bit each, a deadzone stage snaps or sets up the band rescale, a
// second row of seven cells divides again, and an output register adds the
// band base. That is 17 register stages; while the receiver does not stall,
// the block takes one sample per cycle.
//
// Reset loads the documented default calibration and empties every stage.
// When the receiver stalls, the output register holds its beat and each
// stage keeps accepting until the beat ahead of it is blocked, so bubbles in
// the chain are squeezed out before in_i.ready drops.
module joystick_axis_calibrate_deadzone_core import jacd_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  jacd_in_if.sink            in_i,
  jacd_out_if.source         out_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  cfg_t cfg;

  logic      v1 [CELLS+1];
  logic      r1 [CELLS+1];
  div_item_t it1 [CELLS+1];
  logic      v2 [CELLS+1];
  logic      r2 [CELLS+1];
  div_item_t it2 [CELLS+1];

  logic              out_valid_q;
  logic [AXIS_W-1:0] out_axis_q;
  logic [POS_W-1:0]  out_pos_q, out_pos_d;
  logic              out_take;

  assign pready = 1'b1;

  jacd_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg_o   (cfg)
  );

  jacd_entry u_entry (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg),
    .valid_i (in_i.valid),
    .axis_i  (in_i.axis),
    .raw_i   (in_i.raw_sample),
    .ready_o (in_i.ready),
    .valid_o (v1[0]),
    .item_o  (it1[0]),
    .ready_i (r1[0])
  );

  // Segment divider: cell g resolves quotient bit QUO_W-1-g.
  for (genvar g = 0; g < CELLS; g++) begin : g_div_seg
    jacd_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .shift_i (SHIFT_W'(QUO_W - 1 - g)),
      .valid_i (v1[g]),
      .item_i  (it1[g]),
      .ready_o (r1[g]),
      .valid_o (v1[g+1]),
      .item_o  (it1[g+1]),
      .ready_i (r1[g+1])
    );
  end

  jacd_dzone u_dzone (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .margin_i (cfg.margin),
    .valid_i  (v1[CELLS]),
    .item_i   (it1[CELLS]),
    .ready_o  (r1[CELLS]),
    .valid_o  (v2[0]),
    .item_o   (it2[0]),
    .ready_i  (r2[0])
  );

  // Band rescale divider, same cell row.
  for (genvar g = 0; g < CELLS; g++) begin : g_div_band
    jacd_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .shift_i (SHIFT_W'(QUO_W - 1 - g)),
      .valid_i (v2[g]),
      .item_i  (it2[g]),
      .ready_o (r2[g]),
      .valid_o (v2[g+1]),
      .item_o  (it2[g+1]),
      .ready_i (r2[g+1])
    );
  end

  // Output register: add the band base unless the value was snapped.
  assign out_take      = !out_valid_q || out_o.ready;
  assign r2[CELLS]     = out_take;
  assign out_pos_d     = it2[CELLS].forced ? it2[CELLS].base
                                           : it2[CELLS].base + POS_W'(it2[CELLS].quo);
  assign out_o.valid    = out_valid_q;
  assign out_o.axis_tag = out_axis_q;
  assign out_o.position = out_pos_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_take) begin
      out_valid_q <= v2[CELLS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_take) begin
      out_axis_q <= it2[CELLS].axis;
      out_pos_q  <= out_pos_d;
    end
  end

endmodule

[rtl/jacd_regs.sv]
// APB-style calibration register file.
module jacd_regs import jacd_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output cfg_t               cfg_o
);

  cfg_t     cfg_q, cfg_d;
  reg_idx_e idx;
  logic     wr_en;

  assign idx   = reg_idx_e'(paddr[PADDR_W-1:2]);
  assign wr_en = psel && penable && pwrite;
  assign cfg_o = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (idx)
        REG_CAL_LOW:     cfg_d.cal_low   = pwdata[SAMPLE_W-1:0];
        REG_CAL_HIGH:    cfg_d.cal_high  = pwdata[SAMPLE_W-1:0];
        REG_CENTRE0:     cfg_d.centre[0] = pwdata[SAMPLE_W-1:0];
        REG_CENTRE1:     cfg_d.centre[1] = pwdata[SAMPLE_W-1:0];
        REG_CENTRE2:     cfg_d.centre[2] = pwdata[SAMPLE_W-1:0];
        REG_CENTRE3:     cfg_d.centre[3] = pwdata[SAMPLE_W-1:0];
        REG_DEAD_MARGIN: cfg_d.margin    = pwdata[MARGIN_W-1:0];
        default:         cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_CAL_LOW:     prdata = PDATA_W'(cfg_q.cal_low);
      REG_CAL_HIGH:    prdata = PDATA_W'(cfg_q.cal_high);
      REG_CENTRE0:     prdata = PDATA_W'(cfg_q.centre[0]);
      REG_CENTRE1:     prdata = PDATA_W'(cfg_q.centre[1]);
      REG_CENTRE2:     prdata = PDATA_W'(cfg_q.centre[2]);
      REG_CENTRE3:     prdata = PDATA_W'(cfg_q.centre[3]);
      REG_DEAD_MARGIN: prdata = PDATA_W'(cfg_q.margin);
      default:         prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CFG_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

[rtl/jacd_entry.sv]
// Entry stage: clamp against the calibration points and set up the first division.
module jacd_entry import jacd_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  cfg_t                cfg_i,
  input  logic                valid_i,
  input  logic [AXIS_W-1:0]   axis_i,
  input  logic [SAMPLE_W-1:0] raw_i,
  output logic                ready_o,
  output logic                valid_o,
  output div_item_t           item_o,
  input  logic                ready_i
);

  logic                valid_q;
  div_item_t           item_q, item_d;
  logic [AXIS_W-1:0]   sel;
  logic [SAMPLE_W-1:0] mid;
  logic [SAMPLE_W-1:0] diff;

  assign ready_o = !valid_q || ready_i;
  assign valid_o = valid_q;
  assign item_o  = item_q;

  always_comb begin
    sel  = (axis_i > AXIS_W'(AXES - 1)) ? AXIS_W'(AXES - 1) : axis_i;
    mid  = cfg_i.centre[sel];
    diff = '0;
    item_d      = '0;
    item_d.axis = axis_i;
    priority if (raw_i <= cfg_i.cal_low) begin
      item_d.forced = 1'b1;
      item_d.base   = POS_ZERO;
    end else if (raw_i >= cfg_i.cal_high) begin
      item_d.forced = 1'b1;
      item_d.base   = POS_MAX;
    end else if (raw_i == mid) begin
      item_d.forced = 1'b1;
      item_d.base   = POS_MID;
    end else if (raw_i < mid) begin
      // low segment: (raw - low) * 128 / (mid - low)
      diff        = raw_i - cfg_i.cal_low;
      item_d.rem  = NUM_W'(diff) << SCALE_SH;
      item_d.den  = DEN_W'(mid - cfg_i.cal_low);
      item_d.base = POS_ZERO;
    end else begin
      // high segment: 128 + (raw - mid) * 127 / (high - mid)
      diff        = raw_i - mid;
      item_d.rem  = (NUM_W'(diff) << SCALE_SH) - NUM_W'(diff);
      item_d.den  = DEN_W'(cfg_i.cal_high - mid);
      item_d.base = POS_MID;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o) begin
      item_q <= item_d;
    end
  end

endmodule

[rtl/jacd_cell.sv]
// Divider cell: one restoring quotient bit per stage, then hand the item on.
module jacd_cell import jacd_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [SHIFT_W-1:0] shift_i,
  input  logic               valid_i,
  input  div_item_t          item_i,
  output logic               ready_o,
  output logic               valid_o,
  output div_item_t          item_o,
  input  logic               ready_i
);

  logic             valid_q;
  div_item_t        item_q, item_d;
  logic [NUM_W-1:0] trial;

  assign ready_o = !valid_q || ready_i;
  assign valid_o = valid_q;
  assign item_o  = item_q;

  always_comb begin
    trial  = NUM_W'(item_i.den) << shift_i;
    item_d = item_i;
    if (item_i.rem >= trial) begin
      item_d.rem          = item_i.rem - trial;
      item_d.quo[shift_i] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o) begin
      item_q <= item_d;
    end
  end

endmodule

[rtl/jacd_dzone.sv]
// Deadzone stage: snap near 0, 128 and 255 and at the band edges, else set up the band rescale division.
module jacd_dzone import jacd_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [MARGIN_W-1:0] margin_i,
  input  logic                valid_i,
  input  div_item_t           item_i,
  output logic                ready_o,
  output logic                valid_o,
  output div_item_t           item_o,
  input  logic                ready_i
);

  logic             valid_q;
  div_item_t        item_q, item_d;
  logic [POS_W-1:0] v, m, lo_a, hi_a, lo_b, hi_b, diff;

  assign ready_o = !valid_q || ready_i;
  assign valid_o = valid_q;
  assign item_o  = item_q;

  always_comb begin
    v    = item_i.forced ? item_i.base : item_i.base + POS_W'(item_i.quo);
    m    = POS_W'(margin_i);
    lo_a = m + POS_W'(1);
    hi_a = POS_LOW_TOP - m;
    lo_b = POS_HI_BASE + m;
    hi_b = POS_HI_TOP - m;
    diff = '0;
    item_d      = '0;
    item_d.axis = item_i.axis;
    priority if (v <= m) begin
      item_d.forced = 1'b1;
      item_d.base   = POS_ZERO;
    end else if (v >= POS_MAX - m) begin
      item_d.forced = 1'b1;
      item_d.base   = POS_MAX;
    end else if (v >= POS_MID - m && v <= POS_MID + m) begin
      item_d.forced = 1'b1;
      item_d.base   = POS_MID;
    end else if (v < POS_MID - m) begin
      // lower band rescales to 0..127
      priority if (v <= lo_a) begin
        item_d.forced = 1'b1;
        item_d.base   = POS_ZERO;
      end else if (v >= hi_a) begin
        item_d.forced = 1'b1;
        item_d.base   = POS_LOW_TOP;
      end else begin
        diff        = v - lo_a;
        item_d.rem  = (NUM_W'(diff) << SCALE_SH) - NUM_W'(diff);
        item_d.den  = DEN_W'(hi_a - lo_a);
        item_d.base = POS_ZERO;
      end
    end else begin
      // upper band rescales to 129..255
      priority if (v <= lo_b) begin
        item_d.forced = 1'b1;
        item_d.base   = POS_HI_BASE;
      end else if (v >= hi_b) begin
        item_d.forced = 1'b1;
        item_d.base   = POS_MAX;
      end else begin
        diff        = v - lo_b;
        item_d.rem  = (NUM_W'(diff) << SCALE_SH) - (NUM_W'(diff) << 1);
        item_d.den  = DEN_W'(hi_b - lo_b);
        item_d.base = POS_HI_BASE;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o) begin
      item_q <= item_d;
    end
  end

endmodule

[dv/tb_joystick_axis_calibrate_deadzone_core.sv]
// Self-checking testbench for the joystick axis calibration and deadzone core.
module tb_joystick_axis_calibrate_deadzone_core;
  import jacd_pkg::*;

  // Cycles without any beat before the run is declared hung; covers the long
  // receiver hold-off, idle bursts, register writes and the pipeline depth.
  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned LONG_HOLD   = 300;
  localparam int unsigned TAIL_CYCLES = 40;
  localparam int unsigned PHASES      = 6;
  localparam int unsigned PHASE_ITEMS = 88;

  localparam int unsigned FULL_SCALE = POS_MAX;
  localparam int unsigned MID_SCALE  = POS_MID;
  localparam int unsigned LOW_TOP    = POS_LOW_TOP;
  localparam int unsigned HI_BASE    = POS_HI_BASE;

  typedef enum logic {ROW_SAMPLE, ROW_CFG} row_kind_e;

  // One directed step: either a register write or a sample beat, the latter
  // with a typed expectation where the answer is obvious.
  typedef struct packed {
    row_kind_e           kind;
    reg_idx_e            idx;
    logic [31:0]         data;
    logic [AXIS_W-1:0]   ax;
    logic [SAMPLE_W-1:0] raw;
    logic                typed;
    logic [POS_W-1:0]    pos;
  } row_t;

  typedef struct packed {
    logic [AXIS_W-1:0] axis_tag;
    logic [POS_W-1:0]  position;
  } position_beat_t;

  localparam int DIRECTED_N = 36;
  localparam row_t DIRECTED_ROWS [DIRECTED_N] = '{
    // reset calibration: ends, exact low/high points, exact centres
    '{ROW_SAMPLE, REG_CAL_LOW, 32'd0, 2'd0, 12'd0,    1'b1, POS_ZERO},
    '{ROW_SAMPLE, REG_CAL_LOW, 32'd0, 2'd1, 12'd10,   1'b1, POS_ZERO},
    '{ROW_SAMPLE, REG_CAL_LOW, 32'd0, 2'd2, 12'd4095, 1'b1, POS_MAX},
    '{ROW_SAMPLE, REG_CAL_LOW, 32'd0, 2'd3, 12'd4080, 1'b1, POS_MAX},
    '{ROW_SAMPLE, REG_CAL_LOW, 32'd0, 2'd0, 12'd2103, 1'b1, POS_MID},
    '{ROW_SAMPLE, REG_CAL_LOW, 32'd0, 2'd1, 12'd1960, 1'b1, POS_MID},
    '{ROW_SAMPLE, REG_CAL_LOW, 32'd0, 2'd2, 12'd1000, 1'b0, POS_ZERO},
    '{ROW_SAMPLE, REG_CAL_LOW, 32'd0, 2'd3, 12'd3000, 1'b0, POS_ZERO},
    '{ROW_SAMPLE, REG_CAL_LOW, 32'd0, 2'd0, 12'd11,   1'b1, POS_ZERO},
    '{ROW_SAMPLE, REG_CAL_LOW, 32'd0, 2'd1, 12'd4079, 1'b0, POS_ZERO},
    // no deadzone at all
    '{ROW_CFG, REG_DEAD_MARGIN, 32'd0, 2'd0, 12'd0, 1'b0, POS_ZERO},
    '{ROW_SAMPLE, REG_CAL_LOW, 32'd0, 2'd0, 12'd2104, 1'b0, POS_ZERO},
    '{ROW_SAMPLE, REG_CAL_LOW, 32'd0, 2'd2, 12'd500,  1'b0, POS_ZERO},
    // widest margin, loaded through junk in the upper bits
    '{ROW_CFG, REG_DEAD_MARGIN, 32'hFFFF_FFFF, 2'd0, 12'd0, 1'b0, POS_ZERO},
    '{ROW_SAMPLE, REG_CAL_LOW, 32'd0, 2'd3, 12'd1964, 1'b1, POS_MID},
    '{ROW_SAMPLE, REG_CAL_LOW, 32'd0, 2'd0, 12'd1200, 1'b0, POS_ZERO},
    '{ROW_SAMPLE, REG_CAL_LOW, 32'd0, 2'd1, 12'd3500, 1'b0, POS_ZERO},
    // inverted calibration: everything above the low point saturates high
    '{ROW_CFG, REG_CAL_LOW,  32'd3000, 2'd0, 12'd0, 1'b0, POS_ZERO},
    '{ROW_CFG, REG_CAL_HIGH, 32'd1000, 2'd0, 12'd0, 1'b0, POS_ZERO},
    '{ROW_SAMPLE, REG_CAL_LOW, 32'd0, 2'd0, 12'd3000, 1'b1, POS_ZERO},
    '{ROW_SAMPLE, REG_CAL_LOW, 32'd0, 2'd1, 12'd3001, 1'b1, POS_MAX},
    '{ROW_SAMPLE, REG_CAL_LOW, 32'd0, 2'd2, 12'd0,    1'b1, POS_ZERO},
    // full span, centres pinned at the span ends
    '{ROW_CFG, REG_CAL_LOW,     32'd0,         2'd0, 12'd0, 1'b0, POS_ZERO},
    '{ROW_CFG, REG_CAL_HIGH,    32'hABCD_EFFF, 2'd0, 12'd0, 1'b0, POS_ZERO},
    '{ROW_CFG, REG_CENTRE0,     32'd0,         2'd0, 12'd0, 1'b0, POS_ZERO},
    '{ROW_CFG, REG_CENTRE1,     32'd4095,      2'd0, 12'd0, 1'b0, POS_ZERO},
    '{ROW_CFG, REG_CENTRE3,     32'h0000_5000, 2'd0, 12'd0, 1'b0, POS_ZERO},
    '{ROW_CFG, REG_DEAD_MARGIN, 32'h0000_0045, 2'd0, 12'd0, 1'b0, POS_ZERO},
    '{ROW_SAMPLE, REG_CAL_LOW, 32'd0, 2'd0, 12'd1,    1'b0, POS_ZERO},
    '{ROW_SAMPLE, REG_CAL_LOW, 32'd0, 2'd1, 12'd4094, 1'b0, POS_ZERO},
    '{ROW_SAMPLE, REG_CAL_LOW, 32'd0, 2'd3, 12'd2048, 1'b0, POS_ZERO},
    '{ROW_SAMPLE, REG_CAL_LOW, 32'd0, 2'd2, 12'd4095, 1'b1, POS_MAX},
    // centre below the low point
    '{ROW_CFG, REG_CAL_LOW, 32'd2000, 2'd0, 12'd0, 1'b0, POS_ZERO},
    '{ROW_CFG, REG_CENTRE2, 32'd100,  2'd0, 12'd0, 1'b0, POS_ZERO},
    '{ROW_SAMPLE, REG_CAL_LOW, 32'd0, 2'd2, 12'd2001, 1'b0, POS_ZERO},
    '{ROW_SAMPLE, REG_CAL_LOW, 32'd0, 2'd0, 12'd0,    1'b1, POS_ZERO}
  };

  logic clk_i = 1'b0;
  logic rst_ni;

  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  jacd_in_if  in_if ();
  jacd_out_if out_if ();

  joystick_axis_calibrate_deadzone_core dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_if),
    .out_o   (out_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Shadow copy of the calibration registers.
  logic [SAMPLE_W-1:0] cfg_low;
  logic [SAMPLE_W-1:0] cfg_high;
  logic [SAMPLE_W-1:0] cfg_centre [AXES];
  logic [MARGIN_W-1:0] cfg_margin;

  position_beat_t position_q [$];
  int unsigned    mismatch_count = 0;
  int unsigned    idle_cycles = 0;
  bit             tx_idling = 1'b1;
  bit             rx_idling = 1'b1;
  bit             hold_req = 1'b0;

  // Clamp at both ends; divide only strictly inside the segment.
  function automatic int unsigned seg_scale(int unsigned v, int unsigned lo, int unsigned hi,
                                            int unsigned out_lo, int unsigned out_hi);
    if (v <= lo) return out_lo;
    if (v >= hi) return out_hi;
    return out_lo + ((v - lo) * (out_hi - out_lo)) / (hi - lo);
  endfunction

  function automatic logic [POS_W-1:0] calib_position(logic [AXIS_W-1:0] ax,
                                                      logic [SAMPLE_W-1:0] raw);
    int unsigned sel, mid, r, lo, hi, m, v;
    sel = 32'(ax);
    if (sel >= AXES) sel = AXES - 1;
    mid = 32'(cfg_centre[sel]);
    r   = 32'(raw);
    lo  = 32'(cfg_low);
    hi  = 32'(cfg_high);
    m   = 32'(cfg_margin);
    if (r <= lo) v = 0;
    else if (r >= hi) v = FULL_SCALE;
    else if (r <= mid) v = seg_scale(r, lo, mid, 0, MID_SCALE);
    else v = seg_scale(r, mid, hi, MID_SCALE, FULL_SCALE);
    // deadzone: low edge, high edge, centre band, then rescale the two bands
    if (v <= m) v = 0;
    else if (v >= FULL_SCALE - m) v = FULL_SCALE;
    else if (v >= MID_SCALE - m && v <= MID_SCALE + m) v = MID_SCALE;
    else if (v < MID_SCALE - m) v = seg_scale(v, m + 1, MID_SCALE - m - 1, 0, LOW_TOP);
    else v = seg_scale(v, MID_SCALE + m + 1, FULL_SCALE - m - 1, HI_BASE, FULL_SCALE);
    return v[POS_W-1:0];
  endfunction

  // Keep the value in the low bits and fill the rest with junk.
  function automatic logic [PDATA_W-1:0] junk_above(int unsigned v, int unsigned w);
    logic [PDATA_W-1:0] mask;
    mask = (32'd1 << w) - 32'd1;
    return (PDATA_W'($urandom()) & ~mask) | (PDATA_W'(v) & mask);
  endfunction

  // Bias samples toward the calibration points, where the branches flip.
  function automatic logic [SAMPLE_W-1:0] pick_sample(logic [AXIS_W-1:0] ax);
    int pick, d;
    d = int'($urandom_range(0, 6)) - 3;
    case ($urandom_range(0, 5))
      0, 1: pick = int'($urandom_range(0, 4095));
      2: pick = int'(cfg_low) + d;
      3: pick = int'(cfg_high) + d;
      4: pick = int'(cfg_centre[ax]) + d;
      default: pick = $urandom_range(0, 1) ? 4095 : 0;
    endcase
    if (pick < 0) pick = 0;
    if (pick > 4095) pick = 4095;
    return pick[SAMPLE_W-1:0];
  endfunction

  // Drain the pipeline, then run one APB write and mirror it.
  task automatic cfg_write(input reg_idx_e idx, input logic [PDATA_W-1:0] data);
    in_if.valid <= 1'b0;
    do @(posedge clk_i); while (position_q.size() != 0);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_CAL_LOW:     cfg_low = data[SAMPLE_W-1:0];
      REG_CAL_HIGH:    cfg_high = data[SAMPLE_W-1:0];
      REG_CENTRE0:     cfg_centre[0] = data[SAMPLE_W-1:0];
      REG_CENTRE1:     cfg_centre[1] = data[SAMPLE_W-1:0];
      REG_CENTRE2:     cfg_centre[2] = data[SAMPLE_W-1:0];
      REG_CENTRE3:     cfg_centre[3] = data[SAMPLE_W-1:0];
      REG_DEAD_MARGIN: cfg_margin = data[MARGIN_W-1:0];
      default: ;
    endcase
  endtask

  // Offer one sample beat, hold it until accepted, then queue its position.
  task automatic send_beat(input logic [AXIS_W-1:0] ax, input logic [SAMPLE_W-1:0] raw,
                           input logic typed, input logic [POS_W-1:0] typed_pos);
    position_beat_t beat;
    in_if.valid      <= 1'b1;
    in_if.axis       <= ax;
    in_if.raw_sample <= raw;
    do @(posedge clk_i); while (!in_if.ready);
    beat.axis_tag = ax;
    beat.position = typed ? typed_pos : calib_position(ax, raw);
    position_q.push_back(beat);
  endtask

  task automatic sender_gap();
    if (tx_idling && $urandom_range(0, 3) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk_i);
    end
  endtask

  // Load one calibration setting per phase; every register each time.
  task automatic program_phase(input int unsigned kind);
    int unsigned lo, hi, m;
    int unsigned c [AXES];
    case (kind)
      0: begin
        lo = $urandom_range(0, 400);
        hi = $urandom_range(3600, 4095);
        foreach (c[i]) c[i] = $urandom_range(1500, 2600);
        m = $urandom_range(0, 60);
      end
      1: begin
        lo = 0;
        hi = 4095;
        c[0] = 0;
        c[1] = 4095;
        c[2] = 2048;
        c[3] = $urandom_range(0, 4095);
        m = 63;
      end
      2: begin
        lo = $urandom_range(2048, 4095);
        hi = $urandom_range(0, lo);
        foreach (c[i]) c[i] = $urandom_range(0, 4095);
        m = 0;
      end
      3: begin
        lo = $urandom_range(0, 4095);
        hi = $urandom_range(0, 4095);
        foreach (c[i]) c[i] = $urandom_range(0, 4095);
        m = $urandom_range(0, 63);
      end
      4: begin
        lo = 10;
        hi = 4080;
        c[0] = 2103;
        c[1] = 1960;
        c[2] = 2142;
        c[3] = 1964;
        m = 10;
      end
      default: begin
        lo = $urandom_range(0, 100);
        hi = $urandom_range(4000, 4095);
        foreach (c[i]) c[i] = $urandom_range(1800, 2300);
        m = 60;
      end
    endcase
    cfg_write(REG_CAL_LOW, junk_above(lo, SAMPLE_W));
    cfg_write(REG_CAL_HIGH, junk_above(hi, SAMPLE_W));
    cfg_write(REG_CENTRE0, junk_above(c[0], SAMPLE_W));
    cfg_write(REG_CENTRE1, junk_above(c[1], SAMPLE_W));
    cfg_write(REG_CENTRE2, junk_above(c[2], SAMPLE_W));
    cfg_write(REG_CENTRE3, junk_above(c[3], SAMPLE_W));
    cfg_write(REG_DEAD_MARGIN, junk_above(m, MARGIN_W));
  endtask

  // Receiver: random stall bursts, plus one long hold-off on request.
  initial begin : rx_side
    int unsigned stall_left;
    stall_left = 0;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (!rst_ni) begin
        out_if.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_if.ready <= 1'b0;
      end else if (hold_req) begin
        hold_req = 1'b0;
        stall_left = LONG_HOLD - 1;
        out_if.ready <= 1'b0;
      end else if (rx_idling && $urandom_range(0, 4) == 0) begin
        stall_left = $urandom_range(0, 8);
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  // Compare each position beat with the oldest expectation.
  always @(posedge clk_i) begin : check_positions
    position_beat_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (position_q.size() == 0) begin
        $error("unexpected position beat: axis_tag %0d position %0d",
               out_if.axis_tag, out_if.position);
        mismatch_count++;
      end else begin
        want = position_q.pop_front();
        if (out_if.axis_tag !== want.axis_tag) begin
          $error("axis_tag expected %0d actual %0d", want.axis_tag, out_if.axis_tag);
          mismatch_count++;
        end
        if (out_if.position !== want.position) begin
          $error("position expected %0d actual %0d", want.position, out_if.position);
          mismatch_count++;
        end
      end
    end
  end

  // Watchdog: count cycles with no beat on either channel.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("tb_joystick_axis_calibrate_deadzone_core NOT OK");
        $finish;
      end
    end
  end

  initial begin : stimulus
    row_t                row;
    logic [AXIS_W-1:0]   ax;
    bit                  quiet;

    rst_ni           <= 1'b0;
    in_if.valid      <= 1'b0;
    in_if.axis       <= '0;
    in_if.raw_sample <= '0;
    psel             <= 1'b0;
    penable          <= 1'b0;
    pwrite           <= 1'b0;
    paddr            <= '0;
    pwdata           <= '0;

    // mirror the documented reset calibration
    cfg_low       = 12'd10;
    cfg_high      = 12'd4080;
    cfg_centre[0] = 12'd2103;
    cfg_centre[1] = 12'd1960;
    cfg_centre[2] = 12'd2142;
    cfg_centre[3] = 12'd1964;
    cfg_margin    = 6'd10;

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < DIRECTED_N; i++) begin
      row = DIRECTED_ROWS[i];
      if (row.kind == ROW_CFG) begin
        cfg_write(row.idx, row.data);
      end else begin
        send_beat(row.ax, row.raw, row.typed, row.pos);
        sender_gap();
      end
    end

    for (int unsigned ph = 0; ph < PHASES; ph++) begin
      program_phase(ph);
      for (int unsigned n = 0; n < PHASE_ITEMS; n++) begin
        // quiet stretches: mid-phase, the long hold-off, and the final phase
        quiet = (ph == PHASES - 1) || (n >= 40 && n < 60) || (ph == 1 && n >= 10 && n < 70);
        tx_idling = !quiet;
        rx_idling = !quiet;
        if (ph == 1 && n == 10) hold_req = 1'b1;
        ax = AXIS_W'($urandom_range(0, AXES - 1));
        send_beat(ax, pick_sample(ax), 1'b0, POS_ZERO);
        sender_gap();
      end
    end

    in_if.valid <= 1'b0;
    while (position_q.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("tb_joystick_axis_calibrate_deadzone_core OK");
    end else begin
      $display("tb_joystick_axis_calibrate_deadzone_core NOT OK");
    end
    $finish;
  end

endmodule
